FILE: rtl/rmh_pkg.sv
// ----------------------------------------------------------------------------
// rmh_pkg
// Types and constants for the readmemh-style hex text stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmh_pkg;

  localparam int unsigned LineCountBits = 20;
  localparam int unsigned LineNumBits   = 20;

  localparam logic [31:0] TopNibble = 32'hf000_0000;
  localparam logic [31:0] WordStep  = 32'd4;

  localparam logic [7:0] ChAt      = 8'h40;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;

  typedef enum logic [2:0] {
    ModeSpace   = 3'd0,
    ModeSlash   = 3'd1,
    ModeAddr    = 3'd2,
    ModeNum     = 3'd3,
    ModeBlock   = 3'd4,
    ModeStar    = 3'd5,
    ModeLineCom = 3'd6,
    ModeEndWait = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KindWord  = 2'd0,
    KindDone  = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrInvalidChar = 2'd0,
    ErrAfterSlash  = 2'd1,
    ErrOpenComment = 2'd2,
    ErrOverflow    = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [31:0]            word_value;
    logic [31:0]            word_address;
    logic [1:0]             error_code;
    logic [7:0]             offending_char;
    logic [LineNumBits-1:0] line_number;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/readmemh_hex_stream_parser.sv
// ----------------------------------------------------------------------------
// readmemh_hex_stream_parser
// Parses hex memory-image text one character per beat; emits words with
// byte addresses, a done beat at end of input, or a numbered error.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | input     | in_valid_i / in_ready_o | in_data_i  (rmh_pkg::in_t)
//  out      | output    | out_valid_o/out_ready_i | out_data_o (rmh_pkg::out_t)
//
//  One character per cycle while the output is not stalled; its result lands
//  in the output register on the accepting edge and is visible the next cycle.
//  A new beat is taken whenever the output register is empty or drains in
//  the same cycle, so the output stall path is the only throttle.
//  Reset clears scan state, address, line count (to one) and the stop flag.
//  After done or an error, beats are taken and dropped until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module readmemh_hex_stream_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rmh_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rmh_pkg::out_t      out_data_o
);

  rmh_pkg::mode_e                      mode_q, mode_d;
  logic [31:0]                         acc_q, acc_d;
  logic [31:0]                         addr_q, addr_d;
  logic [rmh_pkg::LineCountBits-1:0]   line_q, line_d, line_inc;
  logic                                stop_q, stop_d;
  logic                                out_valid_q, out_valid_d;
  rmh_pkg::out_t                       out_q;

  rmh_pkg::out_t res;
  logic          res_valid;
  logic          in_acc;
  logic [7:0]    ch;
  logic          eof;
  logic          is_digit, is_lower, is_upper, is_hex, is_blank;
  logic [3:0]    nib;
  logic          run_space;
  logic          word_pend;
  logic [31:0]   word_val;
  logic [31:0]   word_addr;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ch       = in_data_i.char_code;
  assign eof      = in_data_i.end_of_input;
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_lower = (ch >= 8'h61) && (ch <= 8'h66);
  assign is_upper = (ch >= 8'h41) && (ch <= 8'h46);
  assign is_hex   = is_digit || is_lower || is_upper;
  assign is_blank = (ch == rmh_pkg::ChSpace) ||
                    ((ch >= rmh_pkg::ChTab) && (ch <= rmh_pkg::ChCr));
  assign nib      = is_digit ? ch[3:0] : (ch[3:0] + 4'd9);
  assign line_inc = (&line_q) ? line_q : (line_q + rmh_pkg::LineCountBits'(1));

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    addr_d    = addr_q;
    line_d    = line_q;
    stop_d    = stop_q;
    res_valid = 1'b0;
    res       = '0;
    run_space = 1'b0;
    word_pend = 1'b0;
    word_val  = acc_q;
    word_addr = addr_q;

    if (!stop_q) begin
      case (mode_q)
        rmh_pkg::ModeSpace: begin
          run_space = 1'b1;
        end
        rmh_pkg::ModeSlash: begin
          if (eof) begin
            res_valid = 1'b1;
            res.result_kind = rmh_pkg::KindError;
            res.error_code  = rmh_pkg::ErrAfterSlash;
            stop_d = 1'b1;
          end else if (ch == rmh_pkg::ChStar) begin
            mode_d = rmh_pkg::ModeBlock;
          end else if (ch == rmh_pkg::ChSlash) begin
            mode_d = rmh_pkg::ModeLineCom;
          end else begin
            res_valid = 1'b1;
            res.result_kind    = rmh_pkg::KindError;
            res.error_code     = rmh_pkg::ErrAfterSlash;
            res.offending_char = ch;
            stop_d = 1'b1;
          end
        end
        rmh_pkg::ModeLineCom: begin
          if (eof) begin
            res_valid = 1'b1;
            res.result_kind = rmh_pkg::KindDone;
            stop_d = 1'b1;
          end else if (ch == rmh_pkg::ChNewline) begin
            mode_d = rmh_pkg::ModeSpace;
          end
        end
        rmh_pkg::ModeBlock: begin
          if (eof) begin
            res_valid = 1'b1;
            res.result_kind = rmh_pkg::KindError;
            res.error_code  = rmh_pkg::ErrOpenComment;
            stop_d = 1'b1;
          end else if (ch == rmh_pkg::ChStar) begin
            mode_d = rmh_pkg::ModeStar;
          end
        end
        rmh_pkg::ModeStar: begin
          if (eof) begin
            res_valid = 1'b1;
            res.result_kind = rmh_pkg::KindError;
            res.error_code  = rmh_pkg::ErrOpenComment;
            stop_d = 1'b1;
          end else if (ch == rmh_pkg::ChSlash) begin
            mode_d = rmh_pkg::ModeSpace;
          end else if (ch != rmh_pkg::ChStar) begin
            mode_d = rmh_pkg::ModeBlock;
          end
        end
        rmh_pkg::ModeNum: begin
          if (!eof && is_hex) begin
            if ((acc_q & rmh_pkg::TopNibble) != '0) begin
              res_valid = 1'b1;
              res.result_kind = rmh_pkg::KindError;
              res.error_code  = rmh_pkg::ErrOverflow;
              stop_d = 1'b1;
            end else begin
              acc_d = {acc_q[27:0], nib};
            end
          end else begin
            word_pend = 1'b1;
            addr_d    = addr_q + rmh_pkg::WordStep;
            mode_d    = rmh_pkg::ModeSpace;
            run_space = 1'b1;
          end
        end
        rmh_pkg::ModeAddr: begin
          if (!eof && is_hex) begin
            acc_d = {acc_q[27:0], nib};
          end else begin
            addr_d    = {acc_q[29:0], 2'b00};
            mode_d    = rmh_pkg::ModeSpace;
            run_space = 1'b1;
          end
        end
        rmh_pkg::ModeEndWait: begin
          res_valid = 1'b1;
          res.result_kind = rmh_pkg::KindDone;
          stop_d = 1'b1;
        end
        default: begin
          res_valid = 1'b1;
          res.result_kind = rmh_pkg::KindDone;
          stop_d = 1'b1;
        end
      endcase

      if (run_space) begin
        if (eof) begin
          res_valid = 1'b1;
          if (word_pend) begin
            mode_d = rmh_pkg::ModeEndWait;
            res.result_kind  = rmh_pkg::KindWord;
            res.word_value   = word_val;
            res.word_address = word_addr;
          end else begin
            res.result_kind = rmh_pkg::KindDone;
            stop_d = 1'b1;
          end
        end else if (ch == rmh_pkg::ChSlash) begin
          mode_d = rmh_pkg::ModeSlash;
        end else if (ch == rmh_pkg::ChAt) begin
          mode_d = rmh_pkg::ModeAddr;
          acc_d  = '0;
        end else if (is_hex) begin
          mode_d = rmh_pkg::ModeNum;
          acc_d  = {28'd0, nib};
        end else if (ch == rmh_pkg::ChNewline) begin
          line_d = line_inc;
        end else if (!is_blank) begin
          res_valid = 1'b1;
          res.result_kind    = rmh_pkg::KindError;
          res.error_code     = rmh_pkg::ErrInvalidChar;
          res.offending_char = ch;
          stop_d = 1'b1;
        end

        if (word_pend && !eof && (is_hex || is_blank || ch == rmh_pkg::ChSlash ||
                                  ch == rmh_pkg::ChAt)) begin
          res_valid = 1'b1;
          res.result_kind  = rmh_pkg::KindWord;
          res.word_value   = word_val;
          res.word_address = word_addr;
        end
      end
    end

    res.line_number = rmh_pkg::LineNumBits'(line_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rmh_pkg::ModeSpace;
      acc_q       <= '0;
      addr_q      <= '0;
      line_q      <= rmh_pkg::LineCountBits'(1);
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        addr_q <= addr_d;
        line_q <= line_d;
        stop_q <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stop_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced after parser stopped");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");

  a_endwait_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !stop_q && mode_q == rmh_pkg::ModeEndWait) |->
      (res_valid && res.result_kind == rmh_pkg::KindDone))
    else $error("end-wait beat did not give done");

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && res.result_kind != rmh_pkg::KindWord) |=> stop_q)
    else $error("done or error beat did not stop the parser");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_kind == rmh_pkg::KindWord ||
                     out_data_o.result_kind == rmh_pkg::KindDone ||
                     out_data_o.result_kind == rmh_pkg::KindError))
    else $error("illegal result kind");
`endif

endmodule

`default_nettype wire
